// ===== rtl/assert_macros.svh =====
// Concurrent assertion shorthands for the checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock, off while in reset
`define LPD_ASSERT(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Check a property on every clock, reset included
`define LPD_ASSERT_ALWAYS(name, prop, msg) \
	name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/lpd_pkg.sv =====
`default_nettype none

package lpd_pkg;

	localparam int NumSensors = 8;
	localparam int SampleW    = 12;
	localparam int ThrW       = 12;
	localparam int GainW      = 16;
	localparam int BaseW      = 11;
	localparam int SpeedW     = 12;
	localparam int PosW       = 11;
	localparam int CntW       = 4;
	localparam int ErrFrac    = 8;
	localparam int NumW       = PosW - 1 + ErrFrac;
	localparam int DivW       = 7;
	localparam int QuotW      = 14;
	localparam int DivSteps   = NumW;
	localparam int StepW      = $clog2(DivSteps);
	localparam int ErrW       = QuotW + 1;
	localparam int DiffW      = ErrW + 1;
	localparam int SumW       = 32;
	localparam int ProdW      = GainW + 1 + SumW;
	localparam int AccW       = ProdW + 1;
	localparam int GainFrac   = 12;
	localparam int CorrW      = AccW - GainFrac;
	localparam int FifoDepth  = 2;
	localparam int PtrW       = $clog2(FifoDepth);
	localparam int CfgIdxW    = 3;
	localparam int CfgDataW   = 16;
	localparam int DivUnit    = 10;

	localparam logic [ThrW-1:0]  ThresholdRst  = ThrW'(400);
	localparam logic [GainW-1:0] GainPRst      = GainW'(4915);
	localparam logic [GainW-1:0] GainIRst      = GainW'(0);
	localparam logic [GainW-1:0] GainDRst      = GainW'(164);
	localparam logic [BaseW-1:0] BaseSpeedRst  = BaseW'(1280);
	localparam logic [BaseW-1:0] SpeedLimitRst = BaseW'(1792);

	localparam logic signed [PosW-1:0] Weight [NumSensors] = '{
		-11'sd400, -11'sd300, -11'sd200, -11'sd100,
		11'sd100, 11'sd200, 11'sd300, 11'sd400
	};

	typedef logic [SampleW-1:0] sample_t;
	typedef logic signed [SpeedW-1:0] speed_t;

	typedef enum logic [CfgIdxW-1:0] {
		REG_LIGHT_LEVEL  = 3'd0,
		REG_GAIN_P       = 3'd1,
		REG_GAIN_I       = 3'd2,
		REG_GAIN_D       = 3'd3,
		REG_BASE_SPEED   = 3'd4,
		REG_SPEED_LIMIT  = 3'd5
	} reg_idx_t;

	typedef struct packed {
		logic [ThrW-1:0]  light_level;
		logic [GainW-1:0] gain_p;
		logic [GainW-1:0] gain_i;
		logic [GainW-1:0] gain_d;
		logic [BaseW-1:0] base_speed;
		logic [BaseW-1:0] speed_limit;
	} cfg_t;

	typedef struct packed {
		logic signed [PosW-1:0]  pos;
		logic [CntW-1:0]         count;
		logic [NumSensors-1:0]   pattern;
	} frame_t;

	typedef struct packed {
		logic full;
		logic empty;
	} fifo_stat_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DIV,
		ST_INT,
		ST_MP,
		ST_MI,
		ST_MD,
		ST_SUM,
		ST_CORR,
		ST_OUT
	} back_state_t;

endpackage

`default_nettype wire

// ===== rtl/lpd_fifo.sv =====
`default_nettype none

module lpd_fifo (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 push,
	input  lpd_pkg::frame_t     wr_data,
	input  wire                 pop,
	output lpd_pkg::frame_t     rd_data,
	output lpd_pkg::fifo_stat_t stat
);
	import lpd_pkg::*;

	frame_t            mem_q [FifoDepth];
	logic [PtrW-1:0]   wr_ptr_q;
	logic [PtrW-1:0]   rd_ptr_q;
	logic [PtrW:0]     fill_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   fill_q <= fill_q + 1'b1;
				2'b01:   fill_q <= fill_q - 1'b1;
				default: fill_q <= fill_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	assign rd_data    = mem_q[rd_ptr_q];
	assign stat.full  = (fill_q == (PtrW+1)'(FifoDepth));
	assign stat.empty = (fill_q == '0);

endmodule

`default_nettype wire

// ===== rtl/lpd_front.sv =====
`default_nettype none

module lpd_front (
	input  wire                  in_valid,
	output logic                 in_ready,
	input  lpd_pkg::sample_t     samples [lpd_pkg::NumSensors],
	input  wire [lpd_pkg::ThrW-1:0] light_level,
	input  lpd_pkg::fifo_stat_t  stat,
	output logic                 push,
	output lpd_pkg::frame_t      frame
);
	import lpd_pkg::*;

	always_comb begin
		frame.pos     = '0;
		frame.count   = '0;
		frame.pattern = '0;
		for (int i = 0; i < NumSensors; i++) begin
			if (samples[i] <= light_level) begin
				frame.pos        = frame.pos + Weight[i];
				frame.count      = frame.count + 1'b1;
				frame.pattern[i] = 1'b1;
			end
		end
	end

	assign in_ready = !stat.full;
	assign push     = in_valid && in_ready;

endmodule

`default_nettype wire

// ===== rtl/lpd_back.sv =====
`default_nettype none

module lpd_back (
	input  wire                  clk,
	input  wire                  arst_n,
	input  lpd_pkg::cfg_t        cfg,
	input  lpd_pkg::frame_t      frame,
	input  lpd_pkg::fifo_stat_t  stat,
	output logic                 pop,
	output logic                 out_valid,
	input  wire                  out_ready,
	output lpd_pkg::speed_t      left_speed,
	output lpd_pkg::speed_t      right_speed,
	output logic [lpd_pkg::NumSensors-1:0] light_pattern
);
	import lpd_pkg::*;

	back_state_t               state_q, state_d;
	logic                      load_out;

	logic                      neg_q;
	logic [NumW-1:0]           num_q;
	logic [DivW-1:0]           div_q;
	logic [DivW-1:0]           rem_q;
	logic [QuotW-1:0]          quo_q;
	logic [StepW-1:0]          step_q;
	logic [NumSensors-1:0]     pattern_q;
	logic signed [ErrW-1:0]    err_q;
	logic signed [ErrW-1:0]    last_err_q;
	logic signed [SumW-1:0]    err_sum_q;
	logic signed [DiffW-1:0]   diff_q;
	logic signed [ProdW-1:0]   prod_q;
	logic signed [AccW-1:0]    acc_q;
	logic signed [CorrW-1:0]   corr_q;
	logic                      out_valid_q;
	speed_t                    left_q;
	speed_t                    right_q;
	logic [NumSensors-1:0]     pat_out_q;

	logic [PosW-2:0]           pos_mag;
	logic [DivW-1:0]           div_init;
	logic [DivW:0]             shifted;
	logic                      ge;
	logic [DivW:0]             shifted_sub;
	logic [DivW-1:0]           rem_nx;
	logic signed [ErrW-1:0]    err_w;
	logic signed [SumW:0]      sum_ext;
	logic signed [SumW-1:0]    sum_sat;
	logic [GainW-1:0]          mul_a;
	logic signed [SumW-1:0]    mul_b;
	logic signed [ProdW-1:0]   mul_p;
	logic signed [AccW-1:0]    acc_rnd;
	logic signed [CorrW:0]     base_x;
	logic signed [CorrW:0]     lim_x;
	logic signed [CorrW:0]     left_raw;
	logic signed [CorrW:0]     right_raw;
	logic signed [CorrW:0]     left_cl;
	logic signed [CorrW:0]     right_cl;

	function automatic logic signed [CorrW:0] clamp_sym(
		input logic signed [CorrW:0] v,
		input logic signed [CorrW:0] lim
	);
		logic signed [CorrW:0] r;
		r = v;
		if (v > lim) begin
			r = lim;
		end else if (v < -lim) begin
			r = -lim;
		end
		return r;
	endfunction

	always_comb begin
		state_d  = state_q;
		pop      = 1'b0;
		load_out = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (!stat.empty) begin
					pop     = 1'b1;
					state_d = ST_DIV;
				end
			end
			ST_DIV: begin
				if (step_q == '0) begin
					state_d = ST_INT;
				end
			end
			ST_INT:  state_d = ST_MP;
			ST_MP:   state_d = ST_MI;
			ST_MI:   state_d = ST_MD;
			ST_MD:   state_d = ST_SUM;
			ST_SUM:  state_d = ST_CORR;
			ST_CORR: state_d = ST_OUT;
			ST_OUT: begin
				if (!out_valid_q || out_ready) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// divider: magnitude of pos * 256 over count * 10, one quotient bit a cycle
	assign pos_mag  = frame.pos[PosW-1] ? (PosW-1)'(-frame.pos) : frame.pos[PosW-2:0];
	assign div_init = (frame.count == '0) ? DivW'(DivUnit)
		: DivW'({3'b000, frame.count} * DivW'(DivUnit));
	assign shifted     = {rem_q, num_q[NumW-1]};
	assign ge          = (shifted >= {1'b0, div_q});
	assign shifted_sub = shifted - {1'b0, div_q};
	assign rem_nx      = ge ? shifted_sub[DivW-1:0] : shifted[DivW-1:0];

	assign err_w   = neg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});
	assign sum_ext = (SumW+1)'(err_sum_q) + (SumW+1)'(err_w);

	always_comb begin
		sum_sat = sum_ext[SumW-1:0];
		if (sum_ext[SumW] != sum_ext[SumW-1]) begin
			sum_sat = sum_ext[SumW] ? {1'b1, {(SumW-1){1'b0}}} : {1'b0, {(SumW-1){1'b1}}};
		end
	end

	always_comb begin
		case (state_q)
			ST_MI: begin
				mul_a = cfg.gain_i;
				mul_b = err_sum_q;
			end
			ST_MD: begin
				mul_a = cfg.gain_d;
				mul_b = SumW'(diff_q);
			end
			default: begin
				mul_a = cfg.gain_p;
				mul_b = SumW'(err_q);
			end
		endcase
	end

	assign mul_p = $signed({1'b0, mul_a}) * mul_b;

	// truncate toward zero on the shift by the gain fraction
	assign acc_rnd = acc_q + (acc_q[AccW-1] ? AccW'({GainFrac{1'b1}}) : AccW'(0));

	assign base_x    = $signed((CorrW+1)'(cfg.base_speed));
	assign lim_x     = $signed((CorrW+1)'(cfg.speed_limit));
	assign left_raw  = base_x + (CorrW+1)'(corr_q);
	assign right_raw = base_x - (CorrW+1)'(corr_q);
	assign left_cl   = clamp_sym(left_raw, lim_x);
	assign right_cl  = clamp_sym(right_raw, lim_x);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			err_sum_q   <= '0;
			last_err_q  <= '0;
		end else begin
			state_q <= state_d;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (state_q == ST_INT) begin
				err_sum_q  <= sum_sat;
				last_err_q <= err_w;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (pop) begin
					neg_q     <= frame.pos[PosW-1];
					num_q     <= {pos_mag, {ErrFrac{1'b0}}};
					div_q     <= div_init;
					rem_q     <= '0;
					quo_q     <= '0;
					step_q    <= StepW'(DivSteps - 1);
					pattern_q <= frame.pattern;
				end
			end
			ST_DIV: begin
				num_q  <= num_q << 1;
				rem_q  <= rem_nx;
				quo_q  <= {quo_q[QuotW-2:0], ge};
				step_q <= step_q - 1'b1;
			end
			ST_INT: begin
				err_q  <= err_w;
				diff_q <= DiffW'(err_w) - DiffW'(last_err_q);
			end
			ST_MP: begin
				prod_q <= mul_p;
				acc_q  <= '0;
			end
			ST_MI, ST_MD: begin
				acc_q  <= acc_q + AccW'(prod_q);
				prod_q <= mul_p;
			end
			ST_SUM: begin
				acc_q <= acc_q + AccW'(prod_q);
			end
			ST_CORR: begin
				corr_q <= acc_rnd[AccW-1:GainFrac];
			end
			ST_OUT: begin
				if (load_out) begin
					left_q    <= left_cl[SpeedW-1:0];
					right_q   <= right_cl[SpeedW-1:0];
					pat_out_q <= pattern_q;
				end
			end
			default: begin
				acc_q <= acc_q;
			end
		endcase
	end

	assign out_valid     = out_valid_q;
	assign left_speed    = left_q;
	assign right_speed   = right_q;
	assign light_pattern = pat_out_q;

endmodule

`default_nettype wire

// ===== rtl/line_position_pid_drive.sv =====
// Line-follower steering. Each input beat carries eight 12-bit reflectance
// samples; a sample at or below light_level counts as light. The front end
// classifies a frame in the cycle it is accepted and parks it in a two-entry
// queue, so up to two frames can wait while an earlier one is processed. The
// sequencer behind the queue takes one frame at a time through a load, the
// bit-serial restoring divide that forms the Q.8 line error, the saturating
// integral update, three passes through one shared 17x32 multiplier for the
// P, I and D terms, rounding toward zero and the speed clamp, and waits
// for a free output register. The result beat gives left and
// right wheel speeds in signed Q.8, clamped to +/- speed_limit, and the
// pattern of light sensors. A configuration write takes effect at the clock
// edge that samples cfg_we high and must be made only while no frame is in
// flight.
`default_nettype none

module line_position_pid_drive (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire                      cfg_we,
	input  wire [lpd_pkg::CfgIdxW-1:0]  cfg_index,
	input  wire [lpd_pkg::CfgDataW-1:0] cfg_data,
	input  wire                      in_valid,
	output logic                     in_ready,
	input  lpd_pkg::sample_t         sample_0,
	input  lpd_pkg::sample_t         sample_1,
	input  lpd_pkg::sample_t         sample_2,
	input  lpd_pkg::sample_t         sample_3,
	input  lpd_pkg::sample_t         sample_4,
	input  lpd_pkg::sample_t         sample_5,
	input  lpd_pkg::sample_t         sample_6,
	input  lpd_pkg::sample_t         sample_7,
	output logic                     out_valid,
	input  wire                      out_ready,
	output lpd_pkg::speed_t          left_speed,
	output lpd_pkg::speed_t          right_speed,
	output logic [lpd_pkg::NumSensors-1:0] light_pattern
);
	import lpd_pkg::*;

	cfg_t        cfg_q;
	sample_t     samples [NumSensors];
	fifo_stat_t  stat;
	frame_t      front_frame;
	frame_t      back_frame;
	logic        push;
	logic        pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.light_level  <= ThresholdRst;
			cfg_q.gain_p       <= GainPRst;
			cfg_q.gain_i       <= GainIRst;
			cfg_q.gain_d       <= GainDRst;
			cfg_q.base_speed   <= BaseSpeedRst;
			cfg_q.speed_limit  <= SpeedLimitRst;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_LIGHT_LEVEL:  cfg_q.light_level  <= cfg_data[ThrW-1:0];
				REG_GAIN_P:       cfg_q.gain_p       <= cfg_data[GainW-1:0];
				REG_GAIN_I:       cfg_q.gain_i       <= cfg_data[GainW-1:0];
				REG_GAIN_D:       cfg_q.gain_d       <= cfg_data[GainW-1:0];
				REG_BASE_SPEED:   cfg_q.base_speed   <= cfg_data[BaseW-1:0];
				REG_SPEED_LIMIT:  cfg_q.speed_limit  <= cfg_data[BaseW-1:0];
				default:          cfg_q              <= cfg_q;
			endcase
		end
	end

	assign samples[0] = sample_0;
	assign samples[1] = sample_1;
	assign samples[2] = sample_2;
	assign samples[3] = sample_3;
	assign samples[4] = sample_4;
	assign samples[5] = sample_5;
	assign samples[6] = sample_6;
	assign samples[7] = sample_7;

	lpd_front u_front (
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.samples      (samples),
		.light_level  (cfg_q.light_level),
		.stat         (stat),
		.push         (push),
		.frame        (front_frame)
	);

	lpd_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_data (front_frame),
		.pop     (pop),
		.rd_data (back_frame),
		.stat    (stat)
	);

	lpd_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_q),
		.frame         (back_frame),
		.stat          (stat),
		.pop           (pop),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.left_speed    (left_speed),
		.right_speed   (right_speed),
		.light_pattern (light_pattern)
	);

endmodule

`default_nettype wire

// ===== rtl/lpd_checker.sv =====
`default_nettype none

`include "assert_macros.svh"

module lpd_checker (
	input wire                      clk,
	input wire                      arst_n,
	input wire                      out_valid,
	input wire                      out_ready,
	input lpd_pkg::speed_t          left_speed,
	input lpd_pkg::speed_t          right_speed,
	input wire [lpd_pkg::NumSensors-1:0] light_pattern
);

	`LPD_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid, "output beat dropped")
	`LPD_ASSERT(a_out_stable,
		out_valid && !out_ready |=> $stable({left_speed, right_speed, light_pattern}),
		"stalled beat changed")
	`LPD_ASSERT_ALWAYS(a_rst_quiet, !arst_n |=> !out_valid, "result during reset")

endmodule

bind line_position_pid_drive lpd_checker u_lpd_checker (.*);

`default_nettype wire
